@@ sv/hid_report_message_deframer_assert.svh @@
// assertion macros of the deframer checker
`ifndef HID_REPORT_MESSAGE_DEFRAMER_ASSERT_SVH
`define HID_REPORT_MESSAGE_DEFRAMER_ASSERT_SVH

// clocked check, muted while reset is asserted
`define HRMD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that stays active through reset
`define HRMD_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/hrmd_pkg.sv @@
// types and constants of the hid report message deframer
package hrmd_pkg;

  localparam logic [5:0] REPORT_LAST_POS = 6'd63;
  localparam logic [5:0] CHANNEL_BYTES   = 6'd4;
  localparam logic [5:0] CMD_POS         = 6'd4;
  localparam logic [5:0] LEN_HI_POS      = 6'd5;
  localparam logic [5:0] LEN_LO_POS      = 6'd6;
  localparam logic [5:0] INIT_DATA_START = 6'd7;
  localparam logic [5:0] CONT_DATA_START = 6'd5;
  localparam int unsigned INIT_BIT       = 7;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } record_kind_e;

  typedef struct packed {
    record_kind_e kind;
    logic [7:0]   payload;
    logic [31:0]  channel;
    logic [7:0]   command;
    logic [15:0]  length;
    logic         last;
    logic         restart;
  } record_t;

endpackage

@@ sv/hid_report_message_deframer.sv @@
// top level of the hid report message deframer
// path: a byte passes the input stage register and the output main register before its result shows on the record port
// throughput: one report byte per cycle while records drain, limited by the output skid
// reset: asynchronous active low, clears position, counters and valids, marks no open message
// payload registers of the input and output stages are not reset
module hid_report_message_deframer
  import hrmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        report_valid_i,
  output logic        report_stall_o,
  input  logic [7:0]  report_byte_i,
  output logic        record_valid_o,
  input  logic        record_stall_i,
  output logic        record_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] channel_id_o,
  output logic [7:0]  command_code_o,
  output logic [15:0] message_length_o,
  output logic        last_of_message_o,
  output logic        restarted_o
);

  // input register stage
  logic       stage_valid_q, stage_valid_d;
  logic [7:0] stage_byte_q;
  logic       report_xfer;
  logic       fire;
  logic       buf_full;

  // core results and buffered record
  logic    rec_valid;
  record_t rec;
  record_t out_rec;

  // the staged byte moves on whenever the skid slot is free
  assign fire           = stage_valid_q && !buf_full;
  assign report_stall_o = stage_valid_q && buf_full;
  assign report_xfer    = report_valid_i && !report_stall_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (report_xfer) begin
      stage_valid_d = 1'b1;
    end else if (fire) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report_xfer) begin
      stage_byte_q <= report_byte_i;
    end
  end

  // framing state and record forming
  hrmd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (stage_byte_q),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  // result register plus skid so input keeps flowing under a short stall
  hrmd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rec_valid),
    .rec_i       (rec),
    .full_o      (buf_full),
    .out_valid_o (record_valid_o),
    .out_stall_i (record_stall_i),
    .out_o       (out_rec)
  );

  assign record_kind_o     = out_rec.kind;
  assign payload_byte_o    = out_rec.payload;
  assign channel_id_o      = out_rec.channel;
  assign command_code_o    = out_rec.command;
  assign message_length_o  = out_rec.length;
  assign last_of_message_o = out_rec.last;
  assign restarted_o       = out_rec.restart;

endmodule

@@ sv/hrmd_core.sv @@
// report position tracking, header latching and payload counting
module hrmd_core
  import hrmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output logic       rec_valid_o,
  output record_t    rec_o
);

  logic [5:0]  pos_q, pos_d;
  logic [31:0] pending_q, pending_d;
  logic [31:0] held_ch_q, held_ch_d;
  logic [7:0]  held_cmd_q, held_cmd_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] held_len_q, held_len_d;
  logic [15:0] remain_q, remain_d;
  logic        in_init_q, in_init_d;
  logic        finished_q, finished_d;
  logic [5:0]  data_start;
  logic [15:0] new_len;

  assign data_start = in_init_q ? INIT_DATA_START : CONT_DATA_START;
  assign new_len    = {len_hi_q, byte_i};

  always_comb begin
    pos_d       = pos_q;
    pending_d   = pending_q;
    held_ch_d   = held_ch_q;
    held_cmd_d  = held_cmd_q;
    len_hi_d    = len_hi_q;
    held_len_d  = held_len_q;
    remain_d    = remain_q;
    in_init_d   = in_init_q;
    finished_d  = finished_q;
    rec_valid_o = 1'b0;
    rec_o.kind    = KIND_HEADER;
    rec_o.payload = 8'd0;
    rec_o.last    = 1'b0;
    rec_o.restart = 1'b0;
    if (fire_i) begin
      if (pos_q < CHANNEL_BYTES) begin
        pending_d = {pending_q[23:0], byte_i};
      end else if (pos_q == CMD_POS) begin
        in_init_d = byte_i[INIT_BIT];
        if (byte_i[INIT_BIT]) begin
          held_ch_d  = pending_q;
          held_cmd_d = byte_i;
        end
      end else if (in_init_q && pos_q == LEN_HI_POS) begin
        len_hi_d = byte_i;
      end else if (in_init_q && pos_q == LEN_LO_POS) begin
        held_len_d    = new_len;
        remain_d      = new_len;
        finished_d    = (new_len == 16'd0);
        rec_valid_o   = 1'b1;
        rec_o.last    = (new_len == 16'd0);
        rec_o.restart = !finished_q;
      end else if (pos_q >= data_start && remain_q != 16'd0) begin
        remain_d      = remain_q - 16'd1;
        if (remain_q == 16'd1) begin
          finished_d = 1'b1;
        end
        rec_valid_o   = 1'b1;
        rec_o.kind    = KIND_PAYLOAD;
        rec_o.payload = byte_i;
        rec_o.last    = (remain_q == 16'd1);
      end
      pos_d = (pos_q >= REPORT_LAST_POS) ? 6'd0 : pos_q + 6'd1;
    end
    rec_o.channel = held_ch_d;
    rec_o.command = held_cmd_d;
    rec_o.length  = held_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      pending_q  <= '0;
      held_ch_q  <= '0;
      held_cmd_q <= '0;
      len_hi_q   <= '0;
      held_len_q <= '0;
      remain_q   <= '0;
      in_init_q  <= 1'b0;
      finished_q <= 1'b1;
    end else begin
      pos_q      <= pos_d;
      pending_q  <= pending_d;
      held_ch_q  <= held_ch_d;
      held_cmd_q <= held_cmd_d;
      len_hi_q   <= len_hi_d;
      held_len_q <= held_len_d;
      remain_q   <= remain_d;
      in_init_q  <= in_init_d;
      finished_q <= finished_d;
    end
  end

endmodule

@@ sv/hrmd_outbuf.sv @@
// two-entry output register with skid stage
module hrmd_outbuf
  import hrmd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  record_t rec_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output record_t out_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  record_t main_q, main_d;
  record_t skid_q, skid_d;
  logic    main_free;

  // main slot can take new data when empty or being drained
  assign main_free = !main_valid_q || !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = rec_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;

endmodule

@@ sv/hrmd_checker.sv @@
// port-level checks of the deframer, bound to the top level
`include "hid_report_message_deframer_assert.svh"

module hrmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        report_stall_o,
  input logic        record_valid_o,
  input logic        record_stall_i,
  input logic        record_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic        restarted_o
);

  `HRMD_ASSERT_RST(a_no_record_in_reset, clk_i, !rst_ni |-> !record_valid_o,
                   "record valid in reset")
  `HRMD_ASSERT(a_record_held, clk_i, rst_ni,
               record_valid_o && record_stall_i |=> record_valid_o,
               "stalled record dropped")
  `HRMD_ASSERT(a_stall_needs_backlog, clk_i, rst_ni, report_stall_o |-> record_valid_o,
               "input stalled with empty output")
  `HRMD_ASSERT(a_payload_no_restart, clk_i, rst_ni,
               record_valid_o && record_kind_o |-> !restarted_o,
               "restart flag on payload record")
  `HRMD_ASSERT(a_header_zero_byte, clk_i, rst_ni,
               record_valid_o && !record_kind_o |-> payload_byte_o == 8'd0,
               "header record carries data")

endmodule

bind hid_report_message_deframer hrmd_checker u_checker (.*);

@@ tb/tb_hid_report_message_deframer.sv @@
// self-checking testbench of the hid report message deframer
`timescale 1ns / 1ps

module tb_hid_report_message_deframer;
  import hrmd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 128;
  localparam int SETTLE_CYCLES  = 10;
  localparam int REPORT_BYTES   = 64;

  // one report of the directed part; an init packet when head bit 7 is set
  typedef struct packed {
    logic [31:0] chan;
    logic [7:0]  head;
    logic [15:0] len;
    logic [7:0]  fill;
    bit          typed;
    bit          t_last;
    bit          t_restart;
  } report_row_t;

  // typed header expectations are checked instead of the predicted header
  localparam report_row_t DIRECTED_ROWS [5] = '{
    '{32'hFFFF_FFFF, 8'h7F, 16'h0000, 8'hFF, 1'b0, 1'b0, 1'b0}, // continuation, nothing open
    '{32'h0000_0000, 8'h80, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b0}, // zero length message
    '{32'h1234_5678, 8'hFF, 16'd60,   8'h10, 1'b1, 1'b0, 1'b0}, // overruns init by 3 bytes
    '{32'hA5A5_5A5A, 8'h86, 16'hFFFF, 8'hEE, 1'b1, 1'b0, 1'b1}, // restart, largest length
    '{32'hA5A5_5A5A, 8'h00, 16'h0000, 8'h33, 1'b0, 1'b0, 1'b0}  // continuation, fills all its data bytes
  };

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        report_valid_i    = 1'b0;
  logic        report_stall_o;
  logic [7:0]  report_byte_i     = 8'h00;
  logic        record_valid_o;
  logic        record_stall_i    = 1'b0;
  logic        record_kind_o;
  logic [7:0]  payload_byte_o;
  logic [31:0] channel_id_o;
  logic [7:0]  command_code_o;
  logic [15:0] message_length_o;
  logic        last_of_message_o;
  logic        restarted_o;

  // predicted deframer state
  logic [5:0]  rpt_pos    = '0;
  logic [31:0] chan_shift = '0;
  logic [31:0] msg_chan   = '0;
  logic [7:0]  msg_cmd    = '0;
  logic [7:0]  len_hi     = '0;
  logic [15:0] msg_len    = '0;
  logic [15:0] left_cnt   = '0;
  bit          init_pkt   = 1'b0;
  bit          msg_done   = 1'b1;

  record_t expected_records[$];
  int      err_cnt   = 0;
  int      idle_cnt  = 0;
  bit      tx_gaps   = 1'b1;
  bit      rx_gaps   = 1'b1;

  hid_report_message_deframer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .report_valid_i    (report_valid_i),
    .report_stall_o    (report_stall_o),
    .report_byte_i     (report_byte_i),
    .record_valid_o    (record_valid_o),
    .record_stall_i    (record_stall_i),
    .record_kind_o     (record_kind_o),
    .payload_byte_o    (payload_byte_o),
    .channel_id_o      (channel_id_o),
    .command_code_o    (command_code_o),
    .message_length_o  (message_length_o),
    .last_of_message_o (last_of_message_o),
    .restarted_o       (restarted_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // advances the predicted state by one report byte, returns 1 when a record results
  function automatic bit predict_record(input logic [7:0] b, output record_t rec);
    logic [5:0] p;
    logic [5:0] first;
    bit         hit;
    p   = rpt_pos;
    hit = 1'b0;
    rec = '0;
    if (p < CHANNEL_BYTES) begin
      chan_shift = {chan_shift[23:0], b};
    end else if (p == CMD_POS) begin
      init_pkt = b[INIT_BIT];
      if (init_pkt) begin
        msg_chan = chan_shift;
        msg_cmd  = b;
      end
    end else if (init_pkt && p == LEN_HI_POS) begin
      len_hi = b;
    end else if (init_pkt && p == LEN_LO_POS) begin
      // restart flag looks at the message before this header
      rec.restart = !msg_done;
      msg_len     = {len_hi, b};
      left_cnt    = msg_len;
      msg_done    = (left_cnt == 16'd0);
      rec.kind    = KIND_HEADER;
      rec.last    = msg_done;
      hit         = 1'b1;
    end else begin
      first = init_pkt ? INIT_DATA_START : CONT_DATA_START;
      if (p >= first && left_cnt != 16'd0) begin
        left_cnt    = left_cnt - 16'd1;
        if (left_cnt == 16'd0) msg_done = 1'b1;
        rec.kind    = KIND_PAYLOAD;
        rec.payload = b;
        rec.last    = (left_cnt == 16'd0);
        hit         = 1'b1;
      end
    end
    if (hit) begin
      rec.channel = msg_chan;
      rec.command = msg_cmd;
      rec.length  = msg_len;
    end
    rpt_pos = (p == REPORT_LAST_POS) ? 6'd0 : p + 6'd1;
    return hit;
  endfunction

  // message lengths: mostly fit one or a few reports, some empty, a few huge
  function automatic logic [15:0] pick_length();
    int q;
    q = $urandom_range(99);
    if (q < 10) return 16'd0;
    if (q < 60) return 16'($urandom_range(57, 1));
    if (q < 90) return 16'($urandom_range(180, 58));
    return 16'($urandom);
  endfunction

  // sends one 64-byte report and records what each transfer should produce
  task automatic send_report(input logic [31:0] chan, input logic [7:0] head,
                             input logic [15:0] len, input logic [7:0] fill, input bit rnd,
                             input bit typed, input bit t_last, input bit t_restart);
    logic [7:0] b;
    record_t    rec;
    bit         hit;
    for (int p = 0; p < REPORT_BYTES; p++) begin
      if (p < CHANNEL_BYTES) b = chan[31 - 8 * p -: 8];
      else if (p == CMD_POS) b = head;
      else if (head[INIT_BIT] && p == LEN_HI_POS) b = len[15:8];
      else if (head[INIT_BIT] && p == LEN_LO_POS) b = len[7:0];
      else b = rnd ? 8'($urandom) : fill + 8'(p);

      @(negedge clk_i);
      while (tx_gaps && $urandom_range(99) < 10) begin
        report_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      report_valid_i <= 1'b1;
      report_byte_i  <= b;
      @(posedge clk_i);
      while (report_stall_o) @(posedge clk_i);

      hit = predict_record(b, rec);
      if (hit) begin
        if (typed && p == LEN_LO_POS && head[INIT_BIT])
          rec = '{KIND_HEADER, 8'h00, chan, head, len, t_last, t_restart};
        expected_records.push_back(rec);
      end
    end
  endtask

  // sender holds off until every expected record has been taken
  task automatic drain_records();
    @(negedge clk_i);
    report_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(negedge clk_i);
  endtask

  // receiver stall, drawn at random with a ten percent chance while enabled
  always @(negedge clk_i) begin
    record_stall_i <= rx_gaps && ($urandom_range(99) < 10);
  end

  // record checker
  always @(posedge clk_i) begin
    record_t exp_rec;
    bit      bad;
    if (rst_ni && record_valid_o && !record_stall_i) begin
      if (expected_records.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected record: kind %0d byte %h chan %h cmd %h len %h last %b rst %b",
                   record_kind_o, payload_byte_o, channel_id_o, command_code_o,
                   message_length_o, last_of_message_o, restarted_o);
      end else begin
        exp_rec = expected_records.pop_front();
        bad = (record_kind_o !== exp_rec.kind) || (payload_byte_o !== exp_rec.payload) ||
              (channel_id_o !== exp_rec.channel) || (command_code_o !== exp_rec.command) ||
              (message_length_o !== exp_rec.length) || (last_of_message_o !== exp_rec.last) ||
              (restarted_o !== exp_rec.restart);
        if (bad) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"record mismatch (exp/act): kind %0d/%0d byte %h/%h chan %h/%h ",
                      "cmd %h/%h len %h/%h last %b/%b rst %b/%b"},
                     exp_rec.kind, record_kind_o, exp_rec.payload, payload_byte_o,
                     exp_rec.channel, channel_id_o, exp_rec.command, command_code_o,
                     exp_rec.length, message_length_o, exp_rec.last, last_of_message_o,
                     exp_rec.restart, restarted_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((report_valid_i && !report_stall_o) || (record_valid_o && !record_stall_i))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int          rnd_bytes;
    int          k;
    int          r;
    logic [7:0]  head;
    logic [15:0] len;
    rnd_bytes = 0;
    k         = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i])
      send_report(DIRECTED_ROWS[i].chan, DIRECTED_ROWS[i].head, DIRECTED_ROWS[i].len,
                  DIRECTED_ROWS[i].fill, 1'b0, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].t_last, DIRECTED_ROWS[i].t_restart);
    drain_records();

    // random reports: mostly well-formed messages, some orphans, restarts and noise
    while (rnd_bytes < RANDOM_BYTES) begin
      // the second random report runs with no idling on either side
      tx_gaps = (k != 1);
      rx_gaps = (k != 1);
      r    = $urandom_range(99);
      head = 8'($urandom_range(127));
      len  = 16'd0;
      if (!msg_done) begin
        if (r >= 90) begin
          head = 8'($urandom);
          len  = 16'($urandom);
        end else if (r >= 80) begin
          head = 8'($urandom_range(255, 128));
          len  = pick_length();
        end
      end else begin
        if (r < 75) begin
          head = 8'($urandom_range(255, 128));
          len  = pick_length();
        end else if (r >= 90) begin
          head = 8'($urandom);
          len  = 16'($urandom);
        end
      end
      send_report($urandom, head, len, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      rnd_bytes += REPORT_BYTES;
      k++;
    end

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    drain_records();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_records.size() != 0) begin
      $display("%0d expected records never arrived", expected_records.size());
      err_cnt += expected_records.size();
    end
    if (err_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
